FILE: sv/hee_pkg.sv
// Shared types and constants of the histogram entropy engine.
// Holds the state enum, status and register codes, divider request types and
// the constant function that builds the log2 fraction table. No dependencies.
package hee_pkg;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [19:0] ENTROPY_MAX   = 20'hFFFFF;
  localparam logic [19:0] FRAC_ONE      = 20'h10000;
  localparam logic [23:0] TOTAL_OUT_MAX = 24'hFFFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BINS_IN_USE = 2'd0;
  localparam logic [1:0] CFG_NORMALIZE   = 2'd1;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_EMPTY     = 3'd1,
    STATUS_ONE_BIN   = 3'd2,
    STATUS_BAD_BIN   = 3'd3,
    STATUS_SATURATED = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_ACCUM,
    S_DRAIN,
    S_WALK,
    S_FLUSH,
    S_DIV_H,
    S_WAIT_H,
    S_DIV_N,
    S_WAIT_N,
    S_RESULT
  } core_state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  // Fraction of log2(1 + i / 2^tbits) in Q.16: square the Q1.31 mantissa 20
  // times, collect one bit per square, round 20 bits down to 16.
  function automatic logic [16:0] log_frac(input int i, input int tbits);
    logic [63:0] y;
    logic [63:0] sq;
    logic [19:0] bits;
    logic [20:0] rnd;
    y    = (64'd1 << 31) + ((64'(i) << 31) >> tbits);
    bits = '0;
    for (int k = 0; k < 20; k++) begin
      sq   = (y * y) >> 31;
      bits = {bits[18:0], 1'b0};
      if (sq >= (64'd1 << 32)) begin
        bits[0] = 1'b1;
        sq      = sq >> 1;
      end
      y = sq;
    end
    rnd = 21'(bits) + 21'd8;
    return rnd[20:4];
  endfunction

endpackage

FILE: sv/hee_ifs.sv
// Channel interfaces of the histogram entropy engine: request, result and
// configuration write. Fixed field widths; no package dependency.
interface hee_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bin_number;
  logic [15:0] bin_weight;
  logic        set_last;

  modport source (output valid, output bin_number, output bin_weight, output set_last,
                  input ready);
  modport sink   (input valid, input bin_number, input bin_weight, input set_last,
                  output ready);
endinterface

interface hee_res_if;
  logic        valid;
  logic        ready;
  logic [19:0] entropy_bits;
  logic [23:0] total_weight;
  logic [2:0]  status;

  modport source (output valid, output entropy_bits, output total_weight, output status,
                  input ready);
  modport sink   (input valid, input entropy_bits, input total_weight, input status,
                  output ready);
endinterface

interface hee_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [8:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: sv/hee_div.sv
// Iterative restoring divider, one quotient bit per cycle, round half up.
// Depends on hee_pkg for widths and the request/response structs.
module hee_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hee_pkg::div_req_t req_i,
  output hee_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [hee_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [hee_pkg::DIV_NUM_W-1:0] num_q;
  logic [hee_pkg::DIV_DEN_W-1:0] rem_q;
  logic [hee_pkg::DIV_DEN_W-1:0] den_q;
  logic [hee_pkg::DIV_DEN_W:0]   shifted;
  logic [hee_pkg::DIV_DEN_W:0]   trial;
  logic                          qbit;
  logic                          round_up;

  assign shifted = {rem_q, num_q[hee_pkg::DIV_NUM_W-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign qbit    = (shifted >= {1'b0, den_q});
  assign round_up = (rem_q >= (den_q - rem_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= req_i.num;
        rem_q  <= '0;
        den_q  <= req_i.den;
      end else if (busy_q) begin
        rem_q <= qbit ? trial[hee_pkg::DIV_DEN_W-1:0] : shifted[hee_pkg::DIV_DEN_W-1:0];
        num_q <= {num_q[hee_pkg::DIV_NUM_W-2:0], qbit};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {hee_pkg::DIV_CNT_W{1'b1}}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q + hee_pkg::DIV_NUM_W'(round_up);

endmodule

FILE: sv/histogram_entropy_engine_core.sv
// Histogram entropy engine top level: bin memory, accumulation, bin walk and result.
// Depends on hee_pkg, the channel interfaces in hee_ifs and the divider hee_div.
//
// Requests add bin_weight into one histogram bin; the bin memory is read,
// modified and written back, with the last write forwarded, so accumulation
// takes one request per cycle. A request with set_last closes the set: the
// block stops taking requests and walks all MAX_BINS bins through the single
// read port, one bin per cycle, summing c*(log2 T - log2 c) and zeroing each
// bin as it goes. The sum is then divided by T in a bit-serial divider, and
// with normalize_enable the entropy is divided again by log2 of bins in use.
// End-of-set time is set by the walk through the one memory port and the
// divider's 64 iterations, with a second division when normalizing. After
// reset the block zeroes all MAX_BINS bins of the bin memory before the
// first request is taken; configuration writes are taken at any time but
// must only be issued while idle. A finished result waits in an output
// register while the next set accumulates.
module histogram_entropy_engine_core #(
  parameter int MAX_BINS       = 256,
  parameter int COUNT_BITS     = 24,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hee_req_if.sink   req_i,
  hee_res_if.source res_o,
  hee_cfg_if.sink   cfg_i
);

  localparam int AW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NW    = $clog2(MAX_BINS + 1);
  localparam int TSIZE = 1 << LOG_TABLE_BITS;
  localparam int LW    = 21;
  localparam int TW    = COUNT_BITS + LW;
  localparam logic [AW-1:0] WA_LAST = AW'(MAX_BINS - 1);
  localparam logic [32:0]   CMAX33  = (33'd1 << COUNT_BITS) - 33'd1;

  // Log2 fraction table, built at elaboration.
  logic [16:0] frac_tab [TSIZE];
  for (genvar g = 0; g < TSIZE; g++) begin : g_frac
    localparam logic [16:0] FV = hee_pkg::log_frac(g, LOG_TABLE_BITS);
    assign frac_tab[g] = FV;
  end

  // Split x into leading-one position and the table index below it.
  function automatic logic [5+LOG_TABLE_BITS-1:0] log_parts(input logic [31:0] x);
    logic [4:0]                     p;
    logic [32+LOG_TABLE_BITS-1:0]   ext;
    p = '0;
    for (int k = 0; k < 32; k++) begin
      if (x[k]) p = 5'(k);
    end
    ext = {x, {LOG_TABLE_BITS{1'b0}}} << (5'd31 - p);
    return {p, ext[30+LOG_TABLE_BITS -: LOG_TABLE_BITS]};
  endfunction

  // Configuration.
  logic [8:0]  bins_q;
  logic        norm_q;
  logic [31:0] n32;
  logic [NW-1:0] n_eff;
  logic        one_bin;

  assign cfg_i.ready = 1'b1;
  assign n32 = (bins_q == 9'd0) ? 32'd1 :
               ((32'(bins_q) > 32'(MAX_BINS)) ? 32'(MAX_BINS) : 32'(bins_q));
  assign n_eff   = NW'(n32);
  assign one_bin = (n32 == 32'd1);

  // State and datapath registers.
  hee_pkg::core_state_e state_q, state_d;
  logic [AW-1:0]         wa_q;
  logic [COUNT_BITS-1:0] total_q;
  logic                  bad_q;
  logic                  sat_q;
  logic                  s1_v_q;
  logic [AW-1:0]         s1_bin_q;
  logic [15:0]           s1_w_q;
  logic                  lw_v_q;
  logic [AW-1:0]         lw_addr_q;
  logic [COUNT_BITS-1:0] lw_data_q;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  p1_v_q, p1_use_q;
  logic                  p2_v_q;
  logic [COUNT_BITS-1:0] p2_c_q;
  logic [LW-1:0]         p2_lc_q;
  logic                  p3_v_q;
  logic [TW-1:0]         term_q;
  logic [63:0]           acc_q;
  logic [LW-1:0]         lt_q;
  logic [LW-1:0]         ln_q;
  logic [19:0]           ent_q;
  logic                  res_valid_q;
  logic [19:0]           res_ent_q;
  logic [23:0]           res_total_q;
  hee_pkg::status_e      res_status_q;

  // Bin memory, read-first, with a registered read port.
  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // Request side.
  logic          req_fire;
  logic          bin_bad;
  logic [AW-1:0] bin_addr;
  logic [32:0]   tot_sum;
  logic          tot_over;

  assign req_i.ready = (state_q == hee_pkg::S_ACCUM);
  assign req_fire    = req_i.valid && req_i.ready;
  assign bin_bad     = (32'(req_i.bin_number) >= n32);
  assign bin_addr    = AW'(req_i.bin_number);
  assign tot_sum     = 33'(total_q) + 33'(req_i.bin_weight);
  assign tot_over    = (tot_sum > CMAX33);

  // Read-modify-write stage; forward the write made on the previous edge.
  logic [COUNT_BITS-1:0] c_old;
  logic [32:0]           bin_sum;
  logic                  bin_over;
  logic [COUNT_BITS-1:0] s1_new;

  assign c_old    = (lw_v_q && lw_addr_q == s1_bin_q) ? lw_data_q : rd_q;
  assign bin_sum  = 33'(c_old) + 33'(s1_w_q);
  assign bin_over = (bin_sum > CMAX33);
  assign s1_new   = bin_over ? COUNT_BITS'(CMAX33) : COUNT_BITS'(bin_sum);

  logic walk_or_clear;
  assign walk_or_clear = (state_q == hee_pkg::S_WALK) || (state_q == hee_pkg::S_CLEAR);
  assign mem_we    = s1_v_q || walk_or_clear;
  assign mem_waddr = s1_v_q ? s1_bin_q : wa_q;
  assign mem_wdata = s1_v_q ? s1_new : '0;
  assign mem_raddr = (state_q == hee_pkg::S_WALK) ? wa_q : bin_addr;

  // Log2 lookups: total and bins in use at drain, bin count in the walk.
  logic [5+LOG_TABLE_BITS-1:0] pt_t, pt_n, pt_c;
  logic [LW-1:0]               lt_d, ln_d, lc_d;
  logic [COUNT_BITS-1:0]       walk_c;

  assign walk_c = p1_use_q ? rd_q : '0;
  assign pt_t = log_parts(32'(total_q));
  assign pt_n = log_parts(32'(n_eff));
  assign pt_c = log_parts(32'(walk_c));
  assign lt_d = {pt_t[5+LOG_TABLE_BITS-1 -: 5], 16'h0}
              + LW'(frac_tab[pt_t[LOG_TABLE_BITS-1:0]]);
  assign ln_d = {pt_n[5+LOG_TABLE_BITS-1 -: 5], 16'h0}
              + LW'(frac_tab[pt_n[LOG_TABLE_BITS-1:0]]);
  assign lc_d = {pt_c[5+LOG_TABLE_BITS-1 -: 5], 16'h0}
              + LW'(frac_tab[pt_c[LOG_TABLE_BITS-1:0]]);

  logic [LW-1:0] dlog;
  logic [TW-1:0] term_d;
  logic [64:0]   acc_sum;

  assign dlog    = (lt_q > p2_lc_q) ? (lt_q - p2_lc_q) : '0;
  assign term_d  = TW'(p2_c_q) * TW'(dlog);
  assign acc_sum = {1'b0, acc_q} + 65'(term_q);

  // Divider.
  hee_pkg::div_req_t div_req;
  hee_pkg::div_rsp_t div_rsp;

  hee_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign div_req.start = (state_q == hee_pkg::S_DIV_H && total_q != '0)
                      || (state_q == hee_pkg::S_DIV_N);
  assign div_req.num   = (state_q == hee_pkg::S_DIV_N) ? 64'({ent_q, 16'h0}) : acc_q;
  assign div_req.den   = (state_q == hee_pkg::S_DIV_N) ? 32'(ln_q) : 32'(total_q);

  logic [19:0] ent_h;
  logic [19:0] ent_n;
  assign ent_h = (div_rsp.quotient > 64'(hee_pkg::ENTROPY_MAX)) ?
                 hee_pkg::ENTROPY_MAX : div_rsp.quotient[19:0];
  assign ent_n = (div_rsp.quotient > 64'(hee_pkg::FRAC_ONE)) ?
                 hee_pkg::FRAC_ONE : div_rsp.quotient[19:0];

  // Result fields.
  logic             tot_big;
  logic             res_load;
  hee_pkg::status_e status_d;
  logic [23:0]      total_out;

  assign tot_big   = (32'(total_q) > 32'(hee_pkg::TOTAL_OUT_MAX));
  assign total_out = tot_big ? hee_pkg::TOTAL_OUT_MAX : 24'(total_q);
  assign res_load  = (state_q == hee_pkg::S_RESULT) && (!res_valid_q || res_o.ready);

  always_comb begin
    if (bad_q) begin
      status_d = hee_pkg::STATUS_BAD_BIN;
    end else if (sat_q || tot_big) begin
      status_d = hee_pkg::STATUS_SATURATED;
    end else if (total_q == '0) begin
      status_d = hee_pkg::STATUS_EMPTY;
    end else if (norm_q && one_bin) begin
      status_d = hee_pkg::STATUS_ONE_BIN;
    end else begin
      status_d = hee_pkg::STATUS_OK;
    end
  end

  // Control state machine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hee_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hee_pkg::S_CLEAR: begin
        if (wa_q == WA_LAST) state_d = hee_pkg::S_ACCUM;
      end
      hee_pkg::S_ACCUM: begin
        if (req_fire && req_i.set_last) state_d = hee_pkg::S_DRAIN;
      end
      hee_pkg::S_DRAIN: begin
        state_d = hee_pkg::S_WALK;
      end
      hee_pkg::S_WALK: begin
        if (wa_q == WA_LAST) state_d = hee_pkg::S_FLUSH;
      end
      hee_pkg::S_FLUSH: begin
        if (!p1_v_q && !p2_v_q && !p3_v_q) state_d = hee_pkg::S_DIV_H;
      end
      hee_pkg::S_DIV_H: begin
        state_d = (total_q == '0) ? hee_pkg::S_RESULT : hee_pkg::S_WAIT_H;
      end
      hee_pkg::S_WAIT_H: begin
        if (div_rsp.done) begin
          state_d = (norm_q && !one_bin) ? hee_pkg::S_DIV_N : hee_pkg::S_RESULT;
        end
      end
      hee_pkg::S_DIV_N: begin
        state_d = hee_pkg::S_WAIT_N;
      end
      hee_pkg::S_WAIT_N: begin
        if (div_rsp.done) state_d = hee_pkg::S_RESULT;
      end
      hee_pkg::S_RESULT: begin
        if (res_load) state_d = hee_pkg::S_ACCUM;
      end
      default: begin
        state_d = hee_pkg::S_CLEAR;
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q       <= 9'd256;
      norm_q       <= 1'b0;
      wa_q         <= '0;
      total_q      <= '0;
      bad_q        <= 1'b0;
      sat_q        <= 1'b0;
      s1_v_q       <= 1'b0;
      s1_bin_q     <= '0;
      s1_w_q       <= '0;
      lw_v_q       <= 1'b0;
      lw_addr_q    <= '0;
      lw_data_q    <= '0;
      p1_v_q       <= 1'b0;
      p1_use_q     <= 1'b0;
      p2_v_q       <= 1'b0;
      p2_c_q       <= '0;
      p2_lc_q      <= '0;
      p3_v_q       <= 1'b0;
      term_q       <= '0;
      acc_q        <= '0;
      lt_q         <= '0;
      ln_q         <= '0;
      ent_q        <= '0;
      res_valid_q  <= 1'b0;
      res_ent_q    <= '0;
      res_total_q  <= '0;
      res_status_q <= hee_pkg::STATUS_OK;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.reg_index)
          hee_pkg::CFG_BINS_IN_USE: bins_q <= cfg_i.wr_data;
          hee_pkg::CFG_NORMALIZE:   norm_q <= cfg_i.wr_data[0];
          default: ;
        endcase
      end

      // Sweep address for the clear pass and the bin walk.
      if (walk_or_clear) begin
        wa_q <= (wa_q == WA_LAST) ? '0 : wa_q + 1'b1;
      end

      // Accept: flag bad bins, add to the total, launch the bin update.
      s1_v_q <= req_fire && !bin_bad && (req_i.bin_weight != 16'd0);
      if (req_fire) begin
        s1_bin_q <= bin_addr;
        s1_w_q   <= req_i.bin_weight;
        if (bin_bad) begin
          bad_q <= 1'b1;
        end else if (req_i.bin_weight != 16'd0) begin
          if (tot_over) begin
            total_q <= COUNT_BITS'(CMAX33);
            sat_q   <= 1'b1;
          end else begin
            total_q <= COUNT_BITS'(tot_sum);
          end
        end
      end

      // Write back the updated bin and remember it for forwarding.
      lw_v_q <= s1_v_q;
      if (s1_v_q) begin
        lw_addr_q <= s1_bin_q;
        lw_data_q <= s1_new;
        if (bin_over) sat_q <= 1'b1;
      end

      if (state_q == hee_pkg::S_DRAIN) begin
        lt_q  <= lt_d;
        ln_q  <= ln_d;
        acc_q <= '0;
      end

      // Walk pipeline: read, log2, multiply, accumulate.
      p1_v_q   <= (state_q == hee_pkg::S_WALK);
      p1_use_q <= (32'(wa_q) < n32);
      p2_v_q   <= p1_v_q;
      p2_c_q   <= walk_c;
      p2_lc_q  <= lc_d;
      p3_v_q   <= p2_v_q;
      term_q   <= term_d;
      if (p3_v_q) begin
        acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
      end

      if (state_q == hee_pkg::S_DIV_H && total_q == '0) begin
        ent_q <= '0;
      end
      if (state_q == hee_pkg::S_WAIT_H && div_rsp.done) begin
        ent_q <= (norm_q && one_bin) ? 20'd0 : ent_h;
      end
      if (state_q == hee_pkg::S_WAIT_N && div_rsp.done) begin
        ent_q <= ent_n;
      end

      // Output register; drop the set's total and flags once loaded.
      if (res_load) begin
        res_valid_q  <= 1'b1;
        res_ent_q    <= ent_q;
        res_total_q  <= total_out;
        res_status_q <= status_d;
        total_q      <= '0;
        bad_q        <= 1'b0;
        sat_q        <= 1'b0;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.entropy_bits = res_ent_q;
  assign res_o.total_weight = res_total_q;
  assign res_o.status       = res_status_q;

`ifndef SYNTHESIS
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.set_last) |=> (state_q == hee_pkg::S_DRAIN))
    else $error("set end did not enter drain");

  a_no_update_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hee_pkg::S_WALK || state_q == hee_pkg::S_CLEAR) |-> !s1_v_q)
    else $error("bin update overlaps memory sweep");

  a_walk_empty_at_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hee_pkg::S_DIV_H) |-> (!p1_v_q && !p2_v_q && !p3_v_q))
    else $error("walk pipeline busy at divide");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule
